/* src/htc_pkg.sv */
// Shared types and constants for the humidity and temperature compensation pipeline.
package htc_pkg;

  localparam int unsigned RAW_T_W  = 14;
  localparam int unsigned RAW_H_W  = 12;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned HUM_W    = 14;
  localparam int unsigned DIV_W    = 32;

  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -13'sd3970;
  localparam logic signed [15:0]         TEMP_MAX     = 16'sd16383;
  localparam logic signed [16:0]         TEMP_REF     = 17'sd2500;
  localparam logic signed [16:0]         SLOPE_BASE   = 17'sd1000;
  localparam logic        [18:0]         LIN_COEF     = 19'd367000;
  localparam logic signed [32:0]         RH_OFFSET    = 33'sd20468000;
  localparam logic        [13:0]         QUAD_COEF    = 14'd15955;
  localparam logic signed [43:0]         SCALE_1000   = 44'sd1000;
  localparam logic signed [43:0]         RH_HIGH      = 44'sd1000000000000;
  localparam logic signed [43:0]         RH_LOW       = 44'sd100000000;
  localparam logic        [HUM_W-1:0]    HUM_MAX      = 14'd10000;
  localparam logic        [HUM_W-1:0]    HUM_MIN      = 14'd1;

  // x / 390625 = (x * DIV_RECIP) >> DIV_SHIFT, low by at most one
  localparam logic [18:0]      DIV_CONST = 19'd390625;
  localparam logic [DIV_W-1:0] DIV_RECIP = 32'd2882303761;
  localparam int unsigned      DIV_SHIFT = 50;

  localparam int unsigned LATENCY = 7;

  typedef struct packed {
    logic              valid;
    logic              over;
    logic              under;
    logic [TEMP_W-1:0] temperature;
  } tag_t;

endpackage

/* src/htc_div.sv */
// Two-stage divide by 390625: reciprocal multiply, then one-step correction.
module htc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  htc_pkg::tag_t             in_tag,
  input  logic [htc_pkg::DIV_W-1:0] in_x,
  output htc_pkg::tag_t             out_tag,
  output logic [htc_pkg::HUM_W-1:0] out_q
);

  htc_pkg::tag_t                 est_tag;
  logic [htc_pkg::DIV_W-1:0]     est_x;
  logic [htc_pkg::HUM_W-1:0]     est_q;
  logic [2*htc_pkg::DIV_W-1:0]   prod;
  logic [htc_pkg::DIV_W:0]       back;
  logic [htc_pkg::DIV_W:0]       rem;
  logic [htc_pkg::HUM_W-1:0]     q_next;

  assign prod = in_x * htc_pkg::DIV_RECIP;

  assign back   = (htc_pkg::DIV_W+1)'(est_q * htc_pkg::DIV_CONST);
  assign rem    = {1'b0, est_x} - back;
  assign q_next = (rem >= (htc_pkg::DIV_W+1)'(htc_pkg::DIV_CONST)) ? est_q + 1'b1 : est_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      est_tag.valid <= 1'b0;
      out_tag.valid <= 1'b0;
    end else begin
      est_tag.valid <= in_tag.valid;
      out_tag.valid <= est_tag.valid;
    end
    est_tag.over        <= in_tag.over;
    est_tag.under       <= in_tag.under;
    est_tag.temperature <= in_tag.temperature;
    est_x               <= in_x;
    est_q               <= prod[htc_pkg::DIV_SHIFT +: htc_pkg::HUM_W];

    out_tag.over        <= est_tag.over;
    out_tag.under       <= est_tag.under;
    out_tag.temperature <= est_tag.temperature;
    out_q               <= q_next;
  end

  a_est_close: assert property (@(posedge clk) disable iff (rst)
    est_tag.valid && !est_tag.over && !est_tag.under
      |-> rem < (htc_pkg::DIV_W+1)'(2 * htc_pkg::DIV_CONST))
    else $error("reciprocal estimate off by more than one");

  a_valid_flow: assert property (@(posedge clk) disable iff (rst)
    in_tag.valid |-> ##2 out_tag.valid)
    else $error("divider lost a transfer");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_tag.valid |-> $past(in_tag.valid, 2))
    else $error("divider produced an extra transfer");

endmodule

/* src/humidity_temperature_compensation.sv */
// Top level: temperature scaling and humidity linearization with temperature compensation.
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+---------------------------
//  input    | start, busy, raw_temperature, raw_humidity| start && !busy at clk edge
//  config   | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
//  result   | done, temperature, humidity               | done high for one cycle
//
//  Seven register stages; one transfer per cycle.
//  Depth set by the humidity polynomial and the reciprocal divide by 1e8.
//  busy is high only during reset; rst clears all stage valid bits and sets the offset to OFFSET_RESET.
//  The receiver cannot stall, so the pipeline never holds.
module humidity_temperature_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [htc_pkg::RAW_T_W-1:0]         raw_temperature,
  input  logic [htc_pkg::RAW_H_W-1:0]         raw_humidity,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [htc_pkg::OFFSET_W-1:0] cfg_data,
  output logic                                done,
  output logic signed [htc_pkg::TEMP_W-1:0]   temperature,
  output logic [htc_pkg::HUM_W-1:0]           humidity
);

  logic                                accept;
  logic signed [htc_pkg::OFFSET_W-1:0] temp_offset;
  logic signed [15:0]                  sum;

  logic                        s1_valid;
  logic [htc_pkg::TEMP_W-1:0]  s1_tc;
  logic [htc_pkg::RAW_H_W-1:0] s1_h;

  logic signed [16:0]          tdel;
  logic signed [16:0]          slope;
  logic signed [33:0]          p1_full;
  logic                        s2_valid;
  logic [htc_pkg::TEMP_W-1:0]  s2_tc;
  logic signed [31:0]          s2_p1;
  logic [23:0]                 s2_hh;
  logic [30:0]                 s2_lin;

  logic                        s3_valid;
  logic [htc_pkg::TEMP_W-1:0]  s3_tc;
  logic signed [32:0]          s3_a;
  logic [37:0]                 s3_q2;

  logic signed [43:0]          s_full;
  htc_pkg::tag_t               s4_tag;
  logic [htc_pkg::DIV_W-1:0]   s4_x;

  htc_pkg::tag_t               div_tag;
  logic [htc_pkg::HUM_W-1:0]   div_q;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_offset <= htc_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      temp_offset <= cfg_data;
    end
  end

  // stage 1: temperature with saturation
  assign sum = {{3{temp_offset[htc_pkg::OFFSET_W-1]}}, temp_offset} + {2'b00, raw_temperature};

  // stage 2: products
  assign tdel    = {{2{s1_tc[htc_pkg::TEMP_W-1]}}, s1_tc} - htc_pkg::TEMP_REF;
  assign slope   = htc_pkg::SLOPE_BASE + {2'b00, s1_h, 3'b000};
  assign p1_full = tdel * slope;

  // stage 4: full scaled sum, in units of 1e-10 percent
  assign s_full = {{11{s3_a[32]}}, s3_a} * htc_pkg::SCALE_1000 - $signed({6'b0, s3_q2});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_tag.valid <= 1'b0;
      done         <= 1'b0;
    end else begin
      s1_valid     <= accept;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_tag.valid <= s3_valid;
      done         <= div_tag.valid;
    end
    s4_tag.temperature <= s3_tc;
    s4_tag.over        <= s_full > htc_pkg::RH_HIGH;
    s4_tag.under       <= s_full < htc_pkg::RH_LOW;
  end

  always_ff @(posedge clk) begin
    s1_tc <= (sum > htc_pkg::TEMP_MAX) ? htc_pkg::TEMP_MAX[htc_pkg::TEMP_W-1:0]
                                       : sum[htc_pkg::TEMP_W-1:0];
    s1_h  <= raw_humidity;

    s2_tc  <= s1_tc;
    s2_p1  <= p1_full[31:0];
    s2_hh  <= s1_h * s1_h;
    s2_lin <= 31'(s1_h * htc_pkg::LIN_COEF);

    s3_tc <= s2_tc;
    s3_a  <= $signed({2'b00, s2_lin}) + {s2_p1[31], s2_p1} - htc_pkg::RH_OFFSET;
    s3_q2 <= 38'(s2_hh * htc_pkg::QUAD_COEF);

    s4_x <= s_full[39:8];

    temperature <= div_tag.temperature;
    humidity    <= div_tag.over  ? htc_pkg::HUM_MAX :
                   div_tag.under ? htc_pkg::HUM_MIN : div_q;
  end

  htc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (s4_tag),
    .in_x    (s4_x),
    .out_tag (div_tag),
    .out_q   (div_q)
  );

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> humidity >= htc_pkg::HUM_MIN && humidity <= htc_pkg::HUM_MAX)
    else $error("humidity outside clamp range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(htc_pkg::LATENCY) done)
    else $error("accepted transfer produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, htc_pkg::LATENCY))
    else $error("result without an accepted transfer");

endmodule

/* verif/humidity_temperature_compensation_tb.sv */
// Testbench for the humidity and temperature compensation pipeline: directed and random readings.
module humidity_temperature_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned CHUNK_ITEMS = 100;
  localparam int unsigned CHUNKS      = 5;

  typedef struct packed {
    logic [htc_pkg::TEMP_W-1:0] temperature;
    logic [htc_pkg::HUM_W-1:0]  humidity;
  } reading_t;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic [htc_pkg::RAW_T_W-1:0]         raw_temperature;
  logic [htc_pkg::RAW_H_W-1:0]         raw_humidity;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic signed [htc_pkg::OFFSET_W-1:0] cfg_data;
  logic                                done;
  logic signed [htc_pkg::TEMP_W-1:0]   temperature;
  logic [htc_pkg::HUM_W-1:0]           humidity;

  reading_t                            pending_readings[$];
  logic signed [htc_pkg::OFFSET_W-1:0] model_offset;
  int unsigned                         idle_pct;
  int unsigned                         mismatch_count;
  int unsigned                         cycle_count;

  humidity_temperature_compensation u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_temperature (raw_temperature),
    .raw_humidity    (raw_humidity),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .done            (done),
    .temperature     (temperature),
    .humidity        (humidity)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Temperature = offset + raw, saturated; humidity formed in units of 1e-10 percent.
  function automatic reading_t compensate_reading(
    logic signed [htc_pkg::OFFSET_W-1:0] offset,
    logic [htc_pkg::RAW_T_W-1:0]         rt,
    logic [htc_pkg::RAW_H_W-1:0]         rh);
    longint   tc;
    longint   h;
    longint   s;
    longint   hum;
    reading_t r;
    tc = longint'(offset) + longint'(rt);
    if (tc > 16383) tc = 16383;
    if (tc < -16384) tc = -16384;
    h = longint'(rh);
    s = -64'sd20468000000 + 64'sd367000000 * h - 64'sd15955 * h * h
        + 64'sd1000 * (tc - 2500) * (1000 + 8 * h);
    if (s > 64'sd1000000000000) hum = 10000;
    else if (s < 64'sd100000000) hum = 1;
    else hum = s / 64'sd100000000;
    r.temperature = tc[htc_pkg::TEMP_W-1:0];
    r.humidity    = hum[htc_pkg::HUM_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && done) begin
      if (pending_readings.size() == 0) begin
        $display("%0t ERROR unexpected result temperature %0d humidity %0d",
                 $time, temperature, humidity);
        mismatch_count++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (temperature !== exp_r.temperature) begin
          $display("%0t ERROR temperature expected %0d got %0d",
                   $time, $signed(exp_r.temperature), temperature);
          mismatch_count++;
        end
        if (humidity !== exp_r.humidity) begin
          $display("%0t ERROR humidity expected %0d got %0d",
                   $time, exp_r.humidity, humidity);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ERROR cycle limit reached", $time);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_reading(logic [htc_pkg::RAW_T_W-1:0] rt,
                              logic [htc_pkg::RAW_H_W-1:0] rh);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    raw_temperature <= rt;
    raw_humidity    <= rh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_readings.push_back(compensate_reading(model_offset, rt, rh));
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (htc_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_offset(logic signed [htc_pkg::OFFSET_W-1:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    model_offset  = value;
  endtask

  function automatic logic [htc_pkg::RAW_T_W-1:0] random_raw_temperature();
    if ($urandom_range(1)) return htc_pkg::RAW_T_W'($urandom);
    return htc_pkg::RAW_T_W'($urandom_range(9000, 5000));
  endfunction

  task automatic test_reset_offset_extremes();
    idle_pct = 0;
    send_reading(14'd0, 12'd0);
    send_reading(14'd16383, 12'd4095);
    send_reading(14'd0, 12'd4095);
    send_reading(14'd16383, 12'd0);
    send_reading(14'd6470, 12'd4095);
    send_reading(14'd6470, 12'd0);
    send_reading(14'd6470, 12'd1500);
    send_reading(14'd6470, 12'd2048);
    send_reading(14'd9970, 12'd1000);
    send_reading(14'd3970, 12'd3000);
  endtask

  task automatic test_temperature_saturation();
    idle_pct = 0;
    write_offset(13'sd4095);
    send_reading(14'd16383, 12'd2000);
    send_reading(14'd12288, 12'd4095);
    send_reading(14'd12289, 12'd0);
    send_reading(14'd12287, 12'd1024);
    send_reading(14'd0, 12'd1500);
    write_offset(-13'sd4096);
    send_reading(14'd0, 12'd4095);
    send_reading(14'd16383, 12'd4095);
    send_reading(14'd6596, 12'd1700);
  endtask

  task automatic test_random_stream(int unsigned sender_idle);
    logic signed [htc_pkg::OFFSET_W-1:0] offset;
    for (int c = 0; c < CHUNKS; c++) begin
      case (c)
        0: offset = -13'sd4010;
        1: offset = -13'sd3940;
        2: offset = htc_pkg::OFFSET_W'($urandom);
        default: offset = htc_pkg::OFFSET_W'($urandom_range(4010, 3940) * -1);
      endcase
      write_offset(offset);
      idle_pct = sender_idle;
      for (int i = 0; i < CHUNK_ITEMS; i++)
        send_reading(random_raw_temperature(), htc_pkg::RAW_H_W'($urandom));
    end
  endtask

  initial begin
    rst             <= 1'b1;
    start           <= 1'b0;
    raw_temperature <= '0;
    raw_humidity    <= '0;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    mismatch_count   = 0;
    cycle_count      = 0;
    idle_pct         = 0;
    model_offset     = htc_pkg::OFFSET_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_offset_extremes();
    test_temperature_saturation();
    test_random_stream(14);
    test_random_stream(58);
    test_random_stream(0);

    drain_pipeline();
    repeat (2 * htc_pkg::LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/htc_pkg.sv
src/htc_div.sv
src/humidity_temperature_compensation.sv
verif/humidity_temperature_compensation_tb.sv
